// ===== src/udfc_pkg.sv =====
// ----------------------------------------------------------------------------
// udfc_pkg
// Shared types, character codes and helpers for the form-field URL decoder.
// ----------------------------------------------------------------------------
package udfc_pkg;

   localparam int unsigned CharWidth   = 8;
   localparam int unsigned LimitWidth  = 16;
   localparam int unsigned ReasonWidth = 3;
   localparam int unsigned CsrIdxWidth = 2;

   // character codes
   localparam logic [CharWidth-1:0] ChNul   = 8'h00;
   localparam logic [CharWidth-1:0] ChNl    = 8'h0A;
   localparam logic [CharWidth-1:0] ChSpace = 8'h20;
   localparam logic [CharWidth-1:0] ChPct   = 8'h25;
   localparam logic [CharWidth-1:0] ChPlus  = 8'h2B;
   localparam logic [CharWidth-1:0] ChZero  = 8'h30;
   localparam logic [CharWidth-1:0] ChNine  = 8'h39;
   localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
   localparam logic [CharWidth-1:0] ChUpF   = 8'h46;
   localparam logic [CharWidth-1:0] HexAlphaBias = 8'h37;  // 'A' - 10

   // register reset values
   localparam logic [CharWidth-1:0]  SeparatorReset  = 8'd38;
   localparam logic [CharWidth-1:0]  TerminatorReset = 8'd32;
   localparam logic [LimitWidth-1:0] LimitReset      = '0;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CsrSeparator  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrTerminator = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrLimit      = 2'd2;

   // stop reasons
   localparam logic [ReasonWidth-1:0] StopNone   = 3'd0;
   localparam logic [ReasonWidth-1:0] StopNul    = 3'd0;
   localparam logic [ReasonWidth-1:0] StopNl     = 3'd1;
   localparam logic [ReasonWidth-1:0] StopSep    = 3'd2;
   localparam logic [ReasonWidth-1:0] StopTerm   = 3'd3;
   localparam logic [ReasonWidth-1:0] StopBudget = 3'd4;

   // escape progress
   localparam logic [1:0] EscIdle   = 2'd0;
   localparam logic [1:0] EscFirst  = 2'd1;
   localparam logic [1:0] EscSecond = 2'd2;
   localparam logic [1:0] EscDone   = 2'd3;

   typedef struct packed {
      logic [1:0]            esc_count;
      logic [CharWidth-1:0]  first_digit;
      logic [CharWidth-1:0]  second_digit;
      logic [LimitWidth-1:0] bytes_left;
      logic                  field_start;
      logic                  unlimited;
   } udfc_state_type;

   typedef struct packed {
      logic [CharWidth-1:0]  separator_char;
      logic [CharWidth-1:0]  terminator_char;
      logic [LimitWidth-1:0] buffer_limit;
   } udfc_cfg_type;

   typedef struct packed {
      logic                   valid;
      logic [CharWidth-1:0]   out_byte;
      logic                   is_end;
      logic [ReasonWidth-1:0] stop_reason;
      logic                   separator_skipped;
   } udfc_result_type;

   // upper-case hex digit to nibble, other characters pass through raw
   function automatic logic [CharWidth-1:0] nibble_of(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] n;
      n = c;
      if (c inside {[ChZero:ChNine]}) begin
         n = c - ChZero;
      end else if (c inside {[ChUpA:ChUpF]}) begin
         n = c - HexAlphaBias;
      end
      return n;
   endfunction

endpackage

// ===== src/udfc_step.sv =====
// ----------------------------------------------------------------------------
// udfc_step
// Next-state and result logic for one character of an encoded field.
// ----------------------------------------------------------------------------
module udfc_step
   import udfc_pkg::*;
(
   input  logic [CharWidth-1:0] in_char,
   input  udfc_cfg_type        cfg,
   input  udfc_state_type      state,
   output udfc_state_type      state_in,
   output udfc_result_type     result
);

   logic                   unl;
   logic [LimitWidth-1:0]  left;
   logic                   stop;
   logic [ReasonWidth-1:0] reason;
   logic                   is_sep;
   logic [1:0]             esc_next;
   logic [CharWidth-1:0]   d1_next;
   logic [CharWidth-1:0]   d2_next;
   logic [CharWidth-1:0]   n1;
   logic [CharWidth-1:0]   n2;
   logic                   emit;
   logic [CharWidth-1:0]   byte_val;

   // budget is sampled on the first character of a field
   assign unl  = state.field_start ? (cfg.buffer_limit == '0) : state.unlimited;
   assign left = state.field_start ? cfg.buffer_limit - LimitWidth'(1) : state.bytes_left;

   assign is_sep = (in_char == cfg.separator_char);

   always_comb begin
      stop   = 1'b1;
      reason = StopNone;
      if (in_char == ChNul) begin
         reason = StopNul;
      end else if (in_char == ChNl) begin
         reason = StopNl;
      end else if (is_sep) begin
         reason = StopSep;
      end else if (in_char == cfg.terminator_char) begin
         reason = StopTerm;
      end else if (!unl && left == '0) begin
         reason = StopBudget;
      end else begin
         stop = 1'b0;
      end
   end

   always_comb begin
      esc_next = state.esc_count;
      d1_next  = state.first_digit;
      d2_next  = state.second_digit;
      emit     = 1'b0;
      byte_val = in_char;
      if (in_char == ChPlus) begin
         emit     = 1'b1;
         byte_val = ChSpace;
      end else if (in_char == ChPct) begin
         esc_next = state.esc_count + 2'd1;
      end else if (state.esc_count != EscIdle) begin
         if (state.esc_count == EscFirst) begin
            d1_next = in_char;
         end else begin
            d2_next = in_char;
         end
         esc_next = state.esc_count + 2'd1;
      end else begin
         emit = 1'b1;
      end
      if (esc_next == EscDone) begin
         emit     = 1'b1;
         byte_val = {n1[3:0], 4'b0000} + n2;
         esc_next = EscIdle;
      end
   end

   assign n1 = nibble_of(d1_next);
   assign n2 = nibble_of(d2_next);

   always_comb begin
      state_in.unlimited    = unl;
      state_in.first_digit  = state.first_digit;
      state_in.second_digit = state.second_digit;
      if (stop) begin
         state_in.esc_count   = EscIdle;
         state_in.bytes_left  = left;
         state_in.field_start = 1'b1;
         result.valid             = 1'b1;
         result.out_byte          = '0;
         result.is_end            = 1'b1;
         result.stop_reason       = reason;
         result.separator_skipped = is_sep;
      end else begin
         state_in.esc_count    = esc_next;
         state_in.first_digit  = d1_next;
         state_in.second_digit = d2_next;
         state_in.bytes_left   = (emit && !unl) ? left - LimitWidth'(1) : left;
         state_in.field_start  = 1'b0;
         result.valid             = emit;
         result.out_byte          = byte_val;
         result.is_end            = 1'b0;
         result.stop_reason       = StopNone;
         result.separator_skipped = 1'b0;
      end
   end

endmodule

// ===== src/url_decode_field_copy.sv =====
// ----------------------------------------------------------------------------
// url_decode_field_copy
// Form-field URL decoder: one raw character in, zero or one decoded byte or
// end item out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_in_char
//  rsp     | out       | rsp_valid / rsp_ready | rsp_out_byte, rsp_is_end,
//          |           |                       | rsp_stop_reason, rsp_separator_skipped
//  csr     | in        | csr_we                | csr_index, csr_data
//
//  One character per cycle while req_ready is high; its result shows in the
//  output register in the cycle after the transfer. The whole decode is a
//  single pass of logic between the field state and the output register.
//  req_ready is high while the output register is empty or being drained.
//  Synchronous reset clears the field state and the output valid flag.
// ----------------------------------------------------------------------------
module url_decode_field_copy
   import udfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CharWidth-1:0]   req_in_char,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CharWidth-1:0]   rsp_out_byte,
   output logic                   rsp_is_end,
   output logic [ReasonWidth-1:0] rsp_stop_reason,
   output logic                   rsp_separator_skipped,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [LimitWidth-1:0]  csr_data
);

   udfc_cfg_type    cfg_ff;
   udfc_state_type  state_ff;
   udfc_state_type  state_in;
   udfc_result_type result;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   udfc_result_type rsp_ff;
   logic            req_xfer;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   udfc_step u_step (
      .in_char  (req_in_char),
      .cfg      (cfg_ff),
      .state    (state_ff),
      .state_in (state_in),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.separator_char  <= SeparatorReset;
         cfg_ff.terminator_char <= TerminatorReset;
         cfg_ff.buffer_limit    <= LimitReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrSeparator:  cfg_ff.separator_char  <= csr_data[CharWidth-1:0];
            CsrTerminator: cfg_ff.terminator_char <= csr_data[CharWidth-1:0];
            CsrLimit:      cfg_ff.buffer_limit    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.esc_count    <= EscIdle;
         state_ff.first_digit  <= '0;
         state_ff.second_digit <= '0;
         state_ff.bytes_left   <= '0;
         state_ff.field_start  <= 1'b1;
         state_ff.unlimited    <= 1'b0;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // output register holds until the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_xfer) begin
         rsp_valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_byte          = rsp_ff.out_byte;
   assign rsp_is_end            = rsp_ff.is_end;
   assign rsp_stop_reason       = rsp_ff.stop_reason;
   assign rsp_separator_skipped = rsp_ff.separator_skipped;

endmodule

// ===== src/udfc_checker.sv =====
// ----------------------------------------------------------------------------
// udfc_checker
// Port-level checks for the form-field URL decoder, bound to the top level.
// ----------------------------------------------------------------------------
module udfc_checker
   import udfc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [CharWidth-1:0]   rsp_out_byte,
   input logic                   rsp_is_end,
   input logic [ReasonWidth-1:0] rsp_stop_reason,
   input logic                   rsp_separator_skipped
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_is_end))
      else $error("rsp payload changed while stalled");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_out_byte == '0)
      else $error("end item carries a nonzero byte");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_end |-> rsp_stop_reason == StopNone && !rsp_separator_skipped)
      else $error("data byte carries end information");

   a_reason_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_stop_reason == StopNul || rsp_stop_reason == StopNl
         || rsp_stop_reason == StopSep || rsp_stop_reason == StopTerm
         || rsp_stop_reason == StopBudget)
      else $error("stop reason out of range");

   a_sep_skipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end && rsp_stop_reason == StopSep |-> rsp_separator_skipped)
      else $error("separator stop not flagged as skipped");

endmodule

bind url_decode_field_copy udfc_checker u_udfc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_out_byte          (rsp_out_byte),
   .rsp_is_end            (rsp_is_end),
   .rsp_stop_reason       (rsp_stop_reason),
   .rsp_separator_skipped (rsp_separator_skipped)
);

// ===== tb/sv/url_decode_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_decode_checker
// Watches the character, result and register ports of the form-field URL
// decoder, predicts the decoded bytes and end items and compares them in order.
// ----------------------------------------------------------------------------
module url_decode_checker
   import udfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [CharWidth-1:0]   req_in_char,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [CharWidth-1:0]   rsp_out_byte,
   input  logic                   rsp_is_end,
   input  logic [ReasonWidth-1:0] rsp_stop_reason,
   input  logic                   rsp_separator_skipped,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [LimitWidth-1:0]  csr_data,
   output int                     pending,
   output int                     mismatches
);

   typedef struct packed {
      logic [CharWidth-1:0]   out_byte;
      logic                   is_end;
      logic [ReasonWidth-1:0] reason;
      logic                   sep_skipped;
   } decoded_item_type;

   decoded_item_type decoded_queue[$];
   int error_count = 0;

   // register copies
   logic [CharWidth-1:0]  sep_cfg;
   logic [CharWidth-1:0]  term_cfg;
   logic [LimitWidth-1:0] limit_cfg;

   // field state
   logic [1:0]            esc_count;
   logic [CharWidth-1:0]  digit_hi;
   logic [CharWidth-1:0]  digit_lo;
   logic [LimitWidth-1:0] budget_left;
   logic                  new_field;
   logic                  no_limit;

   assign mismatches = error_count;

   function automatic logic [CharWidth-1:0] nibble_value(input logic [CharWidth-1:0] c);
      if (c >= ChZero && c <= ChNine) begin
         return c - ChZero;
      end else if (c >= ChUpA && c <= ChUpF) begin
         return c - ChUpA + 8'd10;
      end
      return c;
   endfunction

   function automatic string describe(input decoded_item_type item);
      return $sformatf("byte %02h end %0b reason %0d skipped %0b",
                       item.out_byte, item.is_end, item.reason, item.sep_skipped);
   endfunction

   task automatic report_error(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $time, what);
      end
   endtask

   task automatic decode_char(input logic [CharWidth-1:0] c);
      decoded_item_type       item;
      logic                   stop;
      logic                   emit;
      logic [ReasonWidth-1:0] why;
      item = '0;
      stop = 1'b1;
      emit = 1'b0;
      why  = StopNul;
      // the limit is latched on the first character of a field
      if (new_field) begin
         no_limit    = (limit_cfg == '0);
         budget_left = limit_cfg - LimitWidth'(1);
         new_field   = 1'b0;
      end
      if (c == ChNul) begin
         why = StopNul;
      end else if (c == ChNl) begin
         why = StopNl;
      end else if (c == sep_cfg) begin
         why = StopSep;
      end else if (c == term_cfg) begin
         why = StopTerm;
      end else if (!no_limit && budget_left == '0) begin
         why = StopBudget;
      end else begin
         stop = 1'b0;
      end
      if (stop) begin
         item.is_end      = 1'b1;
         item.reason      = why;
         item.sep_skipped = (c == sep_cfg);
         esc_count        = EscIdle;
         new_field        = 1'b1;
         decoded_queue.push_back(item);
      end else begin
         if (c == ChPlus) begin
            emit          = 1'b1;
            item.out_byte = ChSpace;
         end else if (c == ChPct) begin
            // a percent inside an escape just moves the count on
            esc_count = esc_count + 2'd1;
         end else if (esc_count != EscIdle) begin
            if (esc_count == EscFirst) begin
               digit_hi = c;
            end else begin
               digit_lo = c;
            end
            esc_count = esc_count + 2'd1;
         end else begin
            emit          = 1'b1;
            item.out_byte = c;
         end
         if (esc_count == EscDone) begin
            item.out_byte = CharWidth'({nibble_value(digit_hi), 4'b0000}
                                       + nibble_value(digit_lo));
            emit          = 1'b1;
            esc_count     = EscIdle;
         end
         if (emit) begin
            if (!no_limit) begin
               budget_left = budget_left - LimitWidth'(1);
            end
            decoded_queue.push_back(item);
         end
      end
   endtask

   always @(posedge clock) begin
      decoded_item_type want;
      decoded_item_type got;
      if (reset) begin
         sep_cfg     = SeparatorReset;
         term_cfg    = TerminatorReset;
         limit_cfg   = LimitReset;
         esc_count   = EscIdle;
         digit_hi    = '0;
         digit_lo    = '0;
         budget_left = '0;
         new_field   = 1'b1;
         no_limit    = 1'b0;
         decoded_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrSeparator: begin
                  sep_cfg = csr_data[CharWidth-1:0];
               end
               CsrTerminator: begin
                  term_cfg = csr_data[CharWidth-1:0];
               end
               CsrLimit: begin
                  limit_cfg = csr_data;
               end
               default: begin
               end
            endcase
         end
         // a result never belongs to the character taken at the same edge
         if (rsp_valid && rsp_ready) begin
            got.out_byte    = rsp_out_byte;
            got.is_end      = rsp_is_end;
            got.reason      = rsp_stop_reason;
            got.sep_skipped = rsp_separator_skipped;
            if (decoded_queue.size() == 0) begin
               report_error({"unexpected result: ", describe(got)});
            end else begin
               want = decoded_queue.pop_front();
               if (got !== want) begin
                  report_error({"result mismatch: expected ", describe(want),
                                ", got ", describe(got)});
               end
            end
         end
         if (req_valid && req_ready) begin
            decode_char(req_in_char);
         end
      end
      pending <= decoded_queue.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives form-encoded characters and register settings into the URL decoder
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import udfc_pkg::*;

   localparam logic [CsrIdxWidth-1:0] CsrUnused  = 2'd3;
   localparam int                     StallLimit = 1000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CharWidth-1:0]   req_in_char = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CharWidth-1:0]   rsp_out_byte;
   logic                   rsp_is_end;
   logic [ReasonWidth-1:0] rsp_stop_reason;
   logic                   rsp_separator_skipped;
   logic                   csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [LimitWidth-1:0]  csr_data = '0;

   int pending;
   int mismatches;
   int idle_pct = 20;
   int chars_sent = 0;
   int stall_cycles = 0;
   logic [CharWidth-1:0] cur_sep = SeparatorReset;
   logic [CharWidth-1:0] cur_term = TerminatorReset;

   url_decode_field_copy u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_in_char           (req_in_char),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_is_end            (rsp_is_end),
      .rsp_stop_reason       (rsp_stop_reason),
      .rsp_separator_skipped (rsp_separator_skipped),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   url_decode_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_in_char           (req_in_char),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_is_end            (rsp_is_end),
      .rsp_stop_reason       (rsp_stop_reason),
      .rsp_separator_skipped (rsp_separator_skipped),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .pending               (pending),
      .mismatches            (mismatches)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles == StallLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side stalls
   initial begin : rsp_stalls
      forever begin
         if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send_char(input logic [CharWidth-1:0] c);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i]);
      end
   endtask

   // drain everything; an escape digit may still be in flight with no result
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [CharWidth-1:0] sep, input logic [CharWidth-1:0] term,
                            input logic [LimitWidth-1:0] limit);
      logic [CharWidth-1:0] junk;
      junk      = CharWidth'($urandom_range(0, 255));
      csr_we    <= 1'b1;
      csr_index <= CsrSeparator;
      csr_data  <= {junk, sep};
      @(posedge clock);
      junk      = CharWidth'($urandom_range(0, 255));
      csr_index <= CsrTerminator;
      csr_data  <= {junk, term};
      @(posedge clock);
      csr_index <= CsrLimit;
      csr_data  <= limit;
      @(posedge clock);
      // index beyond the register set must change nothing
      csr_index <= CsrUnused;
      csr_data  <= LimitWidth'($urandom_range(0, 16'hFFFF));
      @(posedge clock);
      csr_we   <= 1'b0;
      cur_sep  = sep;
      cur_term = term;
   endtask

   function automatic logic [CharWidth-1:0] hex_char();
      int r;
      r = $urandom_range(0, 39);
      if (r < 10) begin
         return ChZero + CharWidth'(r);
      end else if (r < 20) begin
         return ChUpA + CharWidth'($urandom_range(0, 5));
      end else if (r < 30) begin
         return ChUpA + 8'h20 + CharWidth'($urandom_range(0, 5));  // lower case
      end
      return CharWidth'($urandom_range(0, 255));
   endfunction

   task automatic send_field(input int len);
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            send_char(ChPlus);
         end else if (r < 40) begin
            send_char(ChPct);
            send_char(hex_char());
            send_char(hex_char());
         end else if (r < 45) begin
            send_char(ChPct);
         end else if (r < 92) begin
            send_char(CharWidth'($urandom_range(8'h21, 8'h7E)));
         end else begin
            send_char(CharWidth'($urandom_range(0, 255)));
         end
      end
      r = $urandom_range(0, 9);
      if (r < 4) begin
         send_char(cur_sep);
      end else if (r < 6) begin
         send_char(cur_term);
      end else if (r == 6) begin
         send_char(ChNl);
      end else if (r == 7) begin
         send_char(ChNul);
      end
   endtask

   task automatic run_phase(input logic [CharWidth-1:0] sep, input logic [CharWidth-1:0] term,
                            input logic [LimitWidth-1:0] limit, input int count,
                            input int idle);
      int target;
      target = chars_sent + count;
      wait_idle();
      configure(sep, term, limit);
      idle_pct = idle;
      while (chars_sent < target) begin
         if ($urandom_range(0, 9) < 8) begin
            send_field($urandom_range(0, 10));
         end else begin
            send_char(CharWidth'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: escapes, plus, stale digits, raw bytes, every stop but the budget
      send_string("%4F+%%A%+1Z");
      send_char(8'hFF);
      send_char(8'h01);
      send_string("%a&\n ");
      send_char(ChNul);
      // budget of two bytes, separator equal to nul
      wait_idle();
      configure(8'h00, 8'hFF, 16'd3);
      send_string("abc");
      send_char(ChNul);
      send_char(8'hFF);

      run_phase(8'h26, 8'h20, 16'd0, 200, 20);
      run_phase(8'h00, 8'hFF, 16'd1, 120, 30);
      run_phase(8'hFF, 8'h00, 16'hFFFF, 200, 10);
      run_phase(8'h3D, 8'h3B, 16'd4, 200, 0);
      run_phase(CharWidth'($urandom_range(0, 255)), CharWidth'($urandom_range(0, 255)),
                LimitWidth'($urandom_range(2, 20)), 200, 40);
      run_phase(ChPct, ChPlus, 16'd6, 150, 20);
      run_phase(CharWidth'($urandom_range(0, 255)), CharWidth'($urandom_range(0, 255)),
                16'd0, 200, 20);
      run_phase(8'h26, ChNl, 16'd2, 150, 15);
      run_phase(8'h26, 8'h20, 16'd8, 130, 0);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/udfc_pkg.sv
src/udfc_step.sv
src/url_decode_field_copy.sv
src/udfc_checker.sv
tb/sv/url_decode_checker.sv
tb/sv/testbench.sv
